// ===== sv/bcb_pkg.sv =====
`timescale 1ns / 1ps
package bcb_pkg;

    localparam int SAMPLE_BITS = 18;
    localparam int COEF_BITS   = 24;
    localparam int FRAC_BITS   = 22;
    // feedforward sum of three taps with a weight of two in the middle
    localparam int OPND_BITS   = SAMPLE_BITS + 2;
    localparam int PROD_BITS   = COEF_BITS + OPND_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int RND_BITS    = ACC_BITS - FRAC_BITS;
    localparam int IDX_BITS    = 3;

    localparam logic [IDX_BITS-1:0] REG_HP_GAIN = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_HP_FB1  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_HP_FB2  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_LP_GAIN = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_LP_FB1  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_LP_FB2  = 3'd5;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_G,
        ST_A1,
        ST_A2,
        ST_FIN,
        ST_RND
    } t_state;

    typedef enum logic [1:0] {
        OP_FF,
        OP_Y1,
        OP_Y2
    } t_opnd;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } t_acc;

    typedef struct packed {
        logic  lp;
        t_opnd opnd;
        t_acc  acc;
        logic  mul_en;
        logic  commit;
        logic  clear;
    } t_ctrl;

endpackage

// ===== sv/cascaded_biquad_bandpass_top.sv =====
`timescale 1ns / 1ps
// cascaded biquad bandpass: highpass biquad then lowpass biquad, direct form I
// input channel: i_in_valid / o_in_ready with i_cmd and i_sample
//   cmd filter: the sample runs through both stages and gives one output item
//   cmd clear: all eight history words go to zero in the accept cycle, no output
// output channel: o_out_valid / i_out_ready with o_filtered
// config: i_cfg_we writes i_cfg_data to the coefficient at i_cfg_idx at once,
//   indexes 0..5 are hp_gain, hp_fb1, hp_fb2, lp_gain, lp_fb1, lp_fb2
// one shared 24 x 20 multiplier with a 46-bit accumulator does all six products,
//   three per stage (three multiplies, a last subtract, a round)
// o_in_ready stays low from a filter item's accept until its lowpass result is committed
// a clear item leaves the block idle, so one clear item is taken every cycle
// the output sits in a register of its own, so a new item is taken while a
//   result still waits; a stalled receiver only holds the sequencer at the end
//   of the next item's lowpass stage until the old result is taken
// reset: coefficients and history go to zero, no output item is pending
module cascaded_biquad_bandpass_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_cmd,
    input  logic signed [bcb_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bcb_pkg::SAMPLE_BITS-1:0] o_filtered,
    input  logic                                   i_cfg_we,
    input  logic        [bcb_pkg::IDX_BITS-1:0]    i_cfg_idx,
    input  logic        [bcb_pkg::COEF_BITS-1:0]   i_cfg_data
);
    import bcb_pkg::*;

    logic signed [COEF_BITS-1:0]   r_hp_gain, r_hp_fb1, r_hp_fb2;
    logic signed [COEF_BITS-1:0]   r_lp_gain, r_lp_fb1, r_lp_fb2;
    logic signed [SAMPLE_BITS-1:0] r_hp_x1, r_hp_x2, r_hp_y1, r_hp_y2;
    logic signed [SAMPLE_BITS-1:0] r_lp_x1, r_lp_x2, r_lp_y1, r_lp_y2;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    t_ctrl                         ctrl;
    logic                          in_ready;
    logic                          out_busy;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [OPND_BITS-1:0]   opnd;
    logic signed [OPND_BITS-1:0]   t0, t1, t2, ff;
    logic signed [SAMPLE_BITS-1:0] y1, y2;
    logic signed [SAMPLE_BITS-1:0] result;

    assign out_busy = r_out_valid && !i_out_ready;

    bcb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_gain <= '0;
            r_hp_fb1  <= '0;
            r_hp_fb2  <= '0;
            r_lp_gain <= '0;
            r_lp_fb1  <= '0;
            r_lp_fb2  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HP_GAIN: r_hp_gain <= $signed(i_cfg_data);
                REG_HP_FB1:  r_hp_fb1  <= $signed(i_cfg_data);
                REG_HP_FB2:  r_hp_fb2  <= $signed(i_cfg_data);
                REG_LP_GAIN: r_lp_gain <= $signed(i_cfg_data);
                REG_LP_FB1:  r_lp_fb1  <= $signed(i_cfg_data);
                REG_LP_FB2:  r_lp_fb2  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_sample <= i_sample;
        end
    end

    // the lowpass input is the highpass output, which sits in r_hp_y1 after its commit
    always_comb begin
        if (ctrl.lp) begin
            t0 = $signed({{2{r_hp_y1[SAMPLE_BITS-1]}}, r_hp_y1});
            t1 = $signed({{2{r_lp_x1[SAMPLE_BITS-1]}}, r_lp_x1});
            t2 = $signed({{2{r_lp_x2[SAMPLE_BITS-1]}}, r_lp_x2});
            ff = t0 + (t1 <<< 1) + t2;
            y1 = r_lp_y1;
            y2 = r_lp_y2;
        end else begin
            t0 = $signed({{2{r_sample[SAMPLE_BITS-1]}}, r_sample});
            t1 = $signed({{2{r_hp_x1[SAMPLE_BITS-1]}}, r_hp_x1});
            t2 = $signed({{2{r_hp_x2[SAMPLE_BITS-1]}}, r_hp_x2});
            ff = t0 - (t1 <<< 1) + t2;
            y1 = r_hp_y1;
            y2 = r_hp_y2;
        end
        case (ctrl.opnd)
            OP_FF: begin
                opnd = ff;
                coef = ctrl.lp ? r_lp_gain : r_hp_gain;
            end
            OP_Y1: begin
                opnd = $signed({{2{y1[SAMPLE_BITS-1]}}, y1});
                coef = ctrl.lp ? r_lp_fb1 : r_hp_fb1;
            end
            OP_Y2: begin
                opnd = $signed({{2{y2[SAMPLE_BITS-1]}}, y2});
                coef = ctrl.lp ? r_lp_fb2 : r_hp_fb2;
            end
            default: begin
                opnd = '0;
                coef = '0;
            end
        endcase
    end

    bcb_mac u_mac (
        .i_clk    (i_clk),
        .i_coef   (coef),
        .i_opnd   (opnd),
        .i_ctrl   (ctrl),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.clear) begin
            r_hp_x1 <= '0;
            r_hp_x2 <= '0;
            r_hp_y1 <= '0;
            r_hp_y2 <= '0;
            r_lp_x1 <= '0;
            r_lp_x2 <= '0;
            r_lp_y1 <= '0;
            r_lp_y2 <= '0;
        end else if (ctrl.commit) begin
            if (ctrl.lp) begin
                r_lp_x2 <= r_lp_x1;
                r_lp_x1 <= r_hp_y1;
                r_lp_y2 <= r_lp_y1;
                r_lp_y1 <= result;
            end else begin
                r_hp_x2 <= r_hp_x1;
                r_hp_x1 <= r_sample;
                r_hp_y2 <= r_hp_y1;
                r_hp_y1 <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit && ctrl.lp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit && ctrl.lp) begin
            r_out <= result;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

endmodule

// ===== sv/bcb_mac.sv =====
`timescale 1ns / 1ps
module bcb_mac (
    input  logic                                    i_clk,
    input  logic signed [bcb_pkg::COEF_BITS-1:0]    i_coef,
    input  logic signed [bcb_pkg::OPND_BITS-1:0]    i_opnd,
    input  bcb_pkg::t_ctrl                          i_ctrl,
    output logic signed [bcb_pkg::SAMPLE_BITS-1:0]  o_result
);
    import bcb_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  rounded;
    logic        [RND_BITS-1:0]  shifted;
    logic                        ovf;

    assign prod_ext = $signed({{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_coef * i_opnd;
        end
        case (i_ctrl.acc)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    // round half up, floor shift, then saturate to the sample range
    always_comb begin
        rounded = r_acc + $signed({{(ACC_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
        shifted = rounded[ACC_BITS-1:FRAC_BITS];
        ovf     = (shifted[RND_BITS-1:SAMPLE_BITS-1] != {(RND_BITS-SAMPLE_BITS+1){1'b0}}) &&
                  (shifted[RND_BITS-1:SAMPLE_BITS-1] != {(RND_BITS-SAMPLE_BITS+1){1'b1}});
        if (!ovf) begin
            o_result = $signed(shifted[SAMPLE_BITS-1:0]);
        end else if (shifted[RND_BITS-1]) begin
            o_result = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
        end else begin
            o_result = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        end
    end

endmodule

// ===== sv/bcb_seq.sv =====
`timescale 1ns / 1ps
module bcb_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cmd,
    input  logic           i_out_busy,
    output logic           o_in_ready,
    output bcb_pkg::t_ctrl o_ctrl
);
    import bcb_pkg::*;

    t_state r_state, n_state;
    logic   r_lp, n_lp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lp    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lp    <= n_lp;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_lp          = r_lp;
        o_in_ready    = 1'b0;
        o_ctrl.lp     = r_lp;
        o_ctrl.opnd   = OP_FF;
        o_ctrl.acc    = ACC_HOLD;
        o_ctrl.mul_en = 1'b0;
        o_ctrl.commit = 1'b0;
        o_ctrl.clear  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_cmd == CMD_CLEAR) begin
                        o_ctrl.clear = 1'b1;
                    end else begin
                        n_lp    = 1'b0;
                        n_state = ST_G;
                    end
                end
            end
            ST_G: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.opnd   = OP_FF;
                n_state       = ST_A1;
            end
            ST_A1: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.opnd   = OP_Y1;
                o_ctrl.acc    = ACC_LOAD;
                n_state       = ST_A2;
            end
            ST_A2: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.opnd   = OP_Y2;
                o_ctrl.acc    = ACC_SUB;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                o_ctrl.acc = ACC_SUB;
                n_state    = ST_RND;
            end
            ST_RND: begin
                if (!r_lp) begin
                    o_ctrl.commit = 1'b1;
                    n_lp          = 1'b1;
                    n_state       = ST_G;
                end else if (!i_out_busy) begin
                    // lowpass result waits here until the output register is free
                    o_ctrl.commit = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/bcb_checker.sv =====
`timescale 1ns / 1ps
module bcb_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   i_cmd,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [bcb_pkg::SAMPLE_BITS-1:0] o_filtered
);
    import bcb_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a filter item drops o_in_ready right after its accept
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_cmd == CMD_FILTER |=> !o_in_ready)
        else $error("block ready right after a filter item");

    // a clear item leaves the block ready right after its accept
    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_cmd == CMD_CLEAR |=> o_in_ready)
        else $error("block not ready after a clear item");

    // a new result appears only as the sequencer returns to idle
    a_out_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while the sequencer is busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered))
        else $error("stalled result dropped or changed");

endmodule

bind cascaded_biquad_bandpass_top bcb_checker u_bcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_cmd       (i_cmd),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_filtered  (o_filtered)
);
